>>> rtl/sswm_pkg.sv
// Shared types and constants of the split-spectrum window mean block.
package sswm_pkg;

  // Field and register widths.
  localparam int VAL_W     = 32;  // sample and result width
  localparam int IDX_W     = 13;  // internal bin index, holds any spectrum length
  localparam int BIN_W     = 12;  // bin index on the result channel
  localparam int HW_W      = 5;   // half width register
  localparam int CFG_W     = 13;  // configuration data, widest register
  localparam int CFG_IDX_W = 1;   // configuration register index

  // Running window sum and sample count.
  localparam int SUM_W = 38;
  localparam int CNT_W = 7;

  // Divider: the dividend is padded to whole digits, one digit per step.
  localparam int DIV_DIGIT  = 8;
  localparam int DIV_W      = 40;
  localparam int DIV_STEPS  = DIV_W / DIV_DIGIT;
  localparam int DIV_STEP_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPECTRUM_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH      = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FETCH,
    ST_ACC,
    ST_DIVIDE
  } state_e;

endpackage

>>> rtl/sswm_in_if.sv
// Input channel of the split-spectrum window mean block.
interface sswm_in_if;
  logic                       valid;
  logic                       ready;
  logic [sswm_pkg::VAL_W-1:0] power_value;
  logic                       frame_start;

  modport source (output valid, output power_value, output frame_start, input ready);
  modport sink (input valid, input power_value, input frame_start, output ready);
endinterface

>>> rtl/sswm_out_if.sv
// Result channel of the split-spectrum window mean block.
interface sswm_out_if;
  logic                       valid;
  logic                       ready;
  logic [sswm_pkg::BIN_W-1:0] bin_index;
  logic [sswm_pkg::VAL_W-1:0] smoothed_value;
  logic                       last_of_run;
  logic                       frame_done;

  modport source (output valid, output bin_index, output smoothed_value,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input bin_index, input smoothed_value,
                input last_of_run, input frame_done, output ready);
endinterface

>>> rtl/sswm_ring.sv
// Sample ring: one write port and two registered read ports.
module sswm_ring #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          waddr_i,
  input  logic [sswm_pkg::VAL_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]          raddr_a_i,
  input  logic [ADDR_W-1:0]          raddr_b_i,
  output logic [sswm_pkg::VAL_W-1:0] rdata_a_o,
  output logic [sswm_pkg::VAL_W-1:0] rdata_b_o
);

  logic [sswm_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> rtl/sswm_div.sv
// Iterative unsigned divider, one quotient digit per cycle.
module sswm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sswm_pkg::SUM_W-1:0] dividend_i,
  input  logic [sswm_pkg::CNT_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [sswm_pkg::VAL_W-1:0] quotient_o
);

  // The dividend shifts out at the top while quotient bits shift in below.
  logic [sswm_pkg::DIV_W-1:0]      acc_q;
  logic [sswm_pkg::CNT_W-1:0]      rem_q;
  logic [sswm_pkg::CNT_W-1:0]      divisor_q;
  logic [sswm_pkg::DIV_STEP_W-1:0] step_q;
  logic                            busy_q;
  logic                            done_q;

  logic [sswm_pkg::CNT_W-1:0]     rem_d;
  logic [sswm_pkg::DIV_DIGIT-1:0] digit;

  always_comb begin
    logic [sswm_pkg::CNT_W:0] trial;
    rem_d = rem_q;
    digit = '0;
    for (int j = 0; j < sswm_pkg::DIV_DIGIT; j++) begin
      trial = {rem_d, acc_q[sswm_pkg::DIV_W-1-j]};
      if (trial >= {1'b0, divisor_q}) begin
        trial = trial - {1'b0, divisor_q};
        digit[sswm_pkg::DIV_DIGIT-1-j] = 1'b1;
      end
      rem_d = trial[sswm_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + sswm_pkg::DIV_STEP_W'(1);
      if (step_q == sswm_pkg::DIV_STEP_W'(sswm_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q     <= sswm_pkg::DIV_W'(dividend_i);
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[sswm_pkg::DIV_W-sswm_pkg::DIV_DIGIT-1:0], digit};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q[sswm_pkg::VAL_W-1:0];

endmodule

>>> rtl/split_spectrum_window_mean.sv
// Top level of the split-spectrum window mean block.
//
// Smooths one spectrum of unsigned power values, given in bin order, with a
// moving average of plus or minus half_width bins. The window is clipped to
// the half of the spectrum that holds the bin (0..N/2 and N/2+1..N-1 read
// from N/2), so the edge windows shrink and each mean divides by the number
// of bins actually in its window, truncating. A bin comes out on the item that
// brings the last sample of its window; the items at bin N/2 and bin N-1 each
// release a run of up to half_width+1 results, and last_of_run marks the end
// of every run. frame_start restarts the spectrum and drops any bins still
// pending; without it the spectrum wraps after bin N-1. spectrum_length and
// half_width take effect at the next bin 0. The samples live in a ring memory
// with two read ports; a running sum is kept in registers and updated by at
// most one add and one subtract per result, and the quotient comes from an
// iterative divider that produces eight bits per cycle. An item that releases
// no result is taken without leaving the idle state. Each result passes through
// a set-up step, a ring read and sum update, a step that launches the divider,
// then the divider and the output register. At bin 0 and at bin N/2+1 the
// window is rebuilt from the ring, one read and one sum update per sample in
// the new window, in place of the single update.
// The next item is taken once the last result of a run sits in the output
// register, even while that register still waits to be read.
module split_spectrum_window_mean #(
  parameter int MAX_POINTS     = 4096,
  parameter int MAX_HALF_WIDTH = 31,
  parameter int RING_DEPTH     = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sswm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sswm_pkg::CFG_W-1:0]     cfg_data_i,
  sswm_in_if.sink                        in_if,
  sswm_out_if.source                     out_if
);

  localparam int IDX_W = sswm_pkg::IDX_W;
  localparam int HW_W  = sswm_pkg::HW_W;
  localparam int SUM_W = sswm_pkg::SUM_W;
  localparam int CNT_W = sswm_pkg::CNT_W;

  // Largest spectrum length the index registers can carry.
  localparam int NMAX_I = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;
  localparam logic [IDX_W-1:0] NMAX = IDX_W'(NMAX_I);

  // Largest usable half width.
  localparam int HMAX_A = (MAX_HALF_WIDTH < (RING_DEPTH - 1) / 2) ?
                          MAX_HALF_WIDTH : (RING_DEPTH - 1) / 2;
  localparam int HMAX_I = (HMAX_A < 31) ? HMAX_A : 31;
  localparam logic [HW_W-1:0] HMAX = HW_W'(HMAX_I);

  // The running sum drops the sample just before the new window, so the ring
  // keeps one sample more than the widest window.
  localparam int RD   = 2 * HMAX_I + 2;
  localparam int RA_W = $clog2(RD);
  localparam logic [RA_W-1:0] RA_LAST = RA_W'(RD - 1);

  // Configuration registers.
  logic [sswm_pkg::CFG_W-1:0] cfg_len_q;
  logic [HW_W-1:0]            cfg_hw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= sswm_pkg::CFG_W'(1024);
      cfg_hw_q  <= HW_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sswm_pkg::CFG_SPECTRUM_LENGTH: cfg_len_q <= cfg_data_i;
        sswm_pkg::CFG_HALF_WIDTH:      cfg_hw_q  <= cfg_data_i[HW_W-1:0];
        default:                       cfg_len_q <= cfg_len_q;
      endcase
    end
  end

  // Control state.
  sswm_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0] frame_n_q, frame_n_d;
  logic [HW_W-1:0]  frame_h_q, frame_h_d;
  logic [IDX_W-1:0] in_idx_q, in_idx_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic [IDX_W-1:0] target_q, target_d;
  logic [RA_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [RA_W-1:0]  half_ptr_q, half_ptr_d;

  // Window: wa is the first sample in it, wb the one after the last.
  logic [IDX_W-1:0] wa_q, wa_d, wb_q, wb_d;
  logic [RA_W-1:0]  pa_q, pa_d, pb_q, pb_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             add_q, add_d, sub_q, sub_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic [sswm_pkg::BIN_W-1:0] bin_q, bin_d;
  logic [sswm_pkg::VAL_W-1:0] val_q, val_d;
  logic                       last_q, last_d;
  logic                       fdone_q, fdone_d;

  // Ring and divider connections.
  logic                       ring_we;
  logic [RA_W-1:0]            ring_waddr;
  logic [sswm_pkg::VAL_W-1:0] rdata_add, rdata_sub;
  logic                       div_start, div_done;
  logic [sswm_pkg::VAL_W-1:0] div_quot;

  // Accept path: position of the new sample and the bins it releases.
  logic             in_ready, acc_in, first;
  logic [IDX_W-1:0] k0, k, n_c, n_eff, n_use, out_use, half_u, h_ext, tgt;
  logic [HW_W-1:0]  h_eff, h_use;
  logic [IDX_W:0]   k_inc;
  logic             rdy, emit;
  logic [RA_W-1:0]  wr_addr;

  assign in_ready = (state_q == sswm_pkg::ST_IDLE);
  assign acc_in   = in_if.valid && in_ready;

  always_comb begin
    k0    = in_if.frame_start ? '0 : in_idx_q;
    k     = (k0 >= frame_n_q) ? '0 : k0;
    first = (k == '0);
    n_c   = (cfg_len_q < IDX_W'(8)) ? IDX_W'(8) : ((cfg_len_q > NMAX) ? NMAX : cfg_len_q);
    n_eff = {n_c[IDX_W-1:1], 1'b0};
    h_eff = (cfg_hw_q > HMAX) ? HMAX : cfg_hw_q;
    n_use   = first ? n_eff : frame_n_q;
    h_use   = first ? h_eff : frame_h_q;
    out_use = first ? '0 : out_idx_q;
    half_u  = n_use >> 1;
    h_ext   = IDX_W'(h_use);
    k_inc   = {1'b0, k} + (IDX_W + 1)'(1);
    wr_addr = first ? '0 : wr_ptr_q;
    // The middle bin and the last bin close their half and flush it.
    if (k == half_u || k == n_use - IDX_W'(1)) begin
      rdy = 1'b1;
      tgt = k;
    end else if (k < half_u) begin
      rdy = (k >= h_ext);
      tgt = k - h_ext;
    end else begin
      rdy = ({1'b0, k} >= {1'b0, h_ext} + {1'b0, half_u} + (IDX_W + 1)'(1));
      tgt = k - h_ext;
    end
    emit = rdy && (out_use <= tgt);
  end

  // Window of the bin being worked on.
  logic [IDX_W-1:0] half_e, lo, hi, bin_a, bin_b;
  logic [IDX_W:0]   i_w, h_w;
  logic             in_lo, need_add, need_sub, restart, out_free;

  always_comb begin
    half_e   = frame_n_q >> 1;
    i_w      = {1'b0, out_idx_q};
    h_w      = (IDX_W + 1)'(frame_h_q);
    in_lo    = (out_idx_q <= half_e);
    lo       = in_lo ? '0 : half_e;
    hi       = in_lo ? half_e : frame_n_q - IDX_W'(1);
    bin_a    = (i_w >= {1'b0, lo} + h_w) ? out_idx_q - IDX_W'(frame_h_q) : lo;
    bin_b    = (i_w + h_w <= {1'b0, hi}) ? IDX_W'(i_w + h_w) : hi;
    need_add = (wb_q <= bin_b);
    need_sub = (wa_q < bin_a);
    restart  = (out_idx_q == '0) || (out_idx_q == half_e + IDX_W'(1));
    out_free = !out_valid_q || out_if.ready;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sswm_pkg::ST_IDLE: begin
        if (acc_in && emit) begin
          state_d = sswm_pkg::ST_START;
        end
      end
      sswm_pkg::ST_START: state_d = sswm_pkg::ST_FETCH;
      sswm_pkg::ST_FETCH: begin
        state_d = (need_add || need_sub) ? sswm_pkg::ST_ACC : sswm_pkg::ST_DIVIDE;
      end
      sswm_pkg::ST_ACC: state_d = sswm_pkg::ST_FETCH;
      sswm_pkg::ST_DIVIDE: begin
        if (div_done && out_free) begin
          state_d = (out_idx_q == target_q) ? sswm_pkg::ST_IDLE : sswm_pkg::ST_START;
        end
      end
      default: state_d = sswm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    frame_n_d   = frame_n_q;
    frame_h_d   = frame_h_q;
    in_idx_d    = in_idx_q;
    out_idx_d   = out_idx_q;
    target_d    = target_q;
    wr_ptr_d    = wr_ptr_q;
    half_ptr_d  = half_ptr_q;
    wa_d        = wa_q;
    wb_d        = wb_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    add_d       = add_q;
    sub_d       = sub_q;
    out_valid_d = out_valid_q && !out_if.ready;
    bin_d       = bin_q;
    val_d       = val_q;
    last_d      = last_q;
    fdone_d     = fdone_q;
    ring_we     = 1'b0;
    ring_waddr  = wr_addr;
    div_start   = 1'b0;

    unique case (state_q)
      sswm_pkg::ST_IDLE: begin
        if (acc_in) begin
          ring_we   = 1'b1;
          frame_n_d = n_use;
          frame_h_d = h_use;
          out_idx_d = out_use;
          target_d  = tgt;
          in_idx_d  = (k_inc >= {1'b0, n_use}) ? '0 : k_inc[IDX_W-1:0];
          wr_ptr_d  = (wr_addr == RA_LAST) ? '0 : wr_addr + RA_W'(1);
          if (k == half_u) begin
            half_ptr_d = wr_addr;
          end
        end
      end
      sswm_pkg::ST_START: begin
        // Bin 0 and the first bin of the upper half open an empty window.
        if (restart) begin
          wa_d  = lo;
          wb_d  = lo;
          pa_d  = (out_idx_q == '0) ? '0 : half_ptr_q;
          pb_d  = (out_idx_q == '0) ? '0 : half_ptr_q;
          sum_d = '0;
          cnt_d = '0;
        end
      end
      sswm_pkg::ST_FETCH: begin
        add_d     = need_add;
        sub_d     = need_sub;
        div_start = !(need_add || need_sub);
      end
      sswm_pkg::ST_ACC: begin
        sum_d = sum_q + (add_q ? SUM_W'(rdata_add) : '0)
                      - (sub_q ? SUM_W'(rdata_sub) : '0);
        cnt_d = cnt_q + CNT_W'(add_q) - CNT_W'(sub_q);
        if (add_q) begin
          wb_d = wb_q + IDX_W'(1);
          pb_d = (pb_q == RA_LAST) ? '0 : pb_q + RA_W'(1);
        end
        if (sub_q) begin
          wa_d = wa_q + IDX_W'(1);
          pa_d = (pa_q == RA_LAST) ? '0 : pa_q + RA_W'(1);
        end
      end
      sswm_pkg::ST_DIVIDE: begin
        if (div_done && out_free) begin
          out_valid_d = 1'b1;
          bin_d       = out_idx_q[sswm_pkg::BIN_W-1:0];
          val_d       = div_quot;
          last_d      = (out_idx_q == target_q);
          fdone_d     = (out_idx_q == frame_n_q - IDX_W'(1));
          out_idx_d   = out_idx_q + IDX_W'(1);
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sswm_pkg::ST_IDLE;
      frame_n_q   <= '0;
      frame_h_q   <= '0;
      in_idx_q    <= '0;
      out_idx_q   <= '0;
      target_q    <= '0;
      wr_ptr_q    <= '0;
      half_ptr_q  <= '0;
      wa_q        <= '0;
      wb_q        <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      add_q       <= 1'b0;
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_n_q   <= frame_n_d;
      frame_h_q   <= frame_h_d;
      in_idx_q    <= in_idx_d;
      out_idx_q   <= out_idx_d;
      target_q    <= target_d;
      wr_ptr_q    <= wr_ptr_d;
      half_ptr_q  <= half_ptr_d;
      wa_q        <= wa_d;
      wb_q        <= wb_d;
      pa_q        <= pa_d;
      pb_q        <= pb_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      add_q       <= add_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    val_q   <= val_d;
    last_q  <= last_d;
    fdone_q <= fdone_d;
  end

  sswm_ring #(
    .DEPTH  (RD),
    .ADDR_W (RA_W)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (ring_we),
    .waddr_i   (ring_waddr),
    .wdata_i   (in_if.power_value),
    .raddr_a_i (pb_q),
    .raddr_b_i (pa_q),
    .rdata_a_o (rdata_add),
    .rdata_b_o (rdata_sub)
  );

  sswm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_if.ready           = in_ready;
  assign out_if.valid          = out_valid_q;
  assign out_if.bin_index      = bin_q;
  assign out_if.smoothed_value = val_q;
  assign out_if.last_of_run    = last_q;
  assign out_if.frame_done     = fdone_q;

`ifndef SYNTH
  // The window handed to the divider is exactly the clipped window of the bin.
  a_window_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sswm_pkg::ST_DIVIDE |-> (wa_q == bin_a && wb_q == bin_b + IDX_W'(1)))
    else $error("window bounds do not match the bin being divided");

  // The divisor is never zero and never exceeds the full window.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sswm_pkg::ST_DIVIDE |->
      (cnt_q != '0 && cnt_q <= (CNT_W'(frame_h_q) << 1) + CNT_W'(1)))
    else $error("window count out of range");

  // A run never goes past the last bin it was released for.
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != sswm_pkg::ST_IDLE |-> out_idx_q <= target_q)
    else $error("result index ran past the run target");

  // The last bin of a spectrum always closes its run.
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.frame_done |-> out_if.last_of_run)
    else $error("frame end result is not the last of its run");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the split-spectrum window mean block.
module tb_top;

  localparam int MAX_POINTS     = 4096;
  localparam int MAX_HALF_WIDTH = 31;
  localparam int RING_DEPTH     = 64;
  localparam int RUN_CAP        = 32;     // most results one item can release

  // An item that releases nothing, or a window rebuild, can still be busy
  // inside the block when the last expected result has come out.
  localparam int SETTLE_CYCLES  = 200;
  // The receiver holds off once for a long stretch after this many results.
  localparam int HOLD_AT        = 22;
  localparam int HOLD_CYCLES    = 500;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int PRINT_CAP      = 40;

  // One smoothed bin as it leaves the block.
  typedef struct packed {
    logic [sswm_pkg::BIN_W-1:0] bin;
    logic [sswm_pkg::VAL_W-1:0] value;
    logic                       last;
    logic                       done;
  } mean_t;

  // Rows of the directed table. A typed row releases exactly one result whose
  // value is the power itself (zero half width), so it is written down here.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_FREE,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [sswm_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [sswm_pkg::CFG_W-1:0]     cfg_data;
    logic [sswm_pkg::VAL_W-1:0]     power;
    logic                           fs;
    logic [sswm_pkg::BIN_W-1:0]     bin;
    logic                           done;
  } stim_row_t;

  localparam int N_DIRECTED = 26;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // Length below range clamps to 8 bins; zero width makes every bin its
    // own mean, so each item gives back its power at once.
    '{ROW_CFG,   sswm_pkg::CFG_SPECTRUM_LENGTH, 13'd0,  32'h0000_0000, 1'b0, 12'd0, 1'b0},
    '{ROW_CFG,   sswm_pkg::CFG_HALF_WIDTH,      13'd0,  32'h0000_0000, 1'b0, 12'd0, 1'b0},
    '{ROW_TYPED, '0,                            '0,     32'h0000_0000, 1'b1, 12'd0, 1'b0},
    '{ROW_TYPED, '0,                            '0,     32'hFFFF_FFFF, 1'b0, 12'd1, 1'b0},
    '{ROW_TYPED, '0,                            '0,     32'hAAAA_AAAA, 1'b0, 12'd2, 1'b0},
    '{ROW_TYPED, '0,                            '0,     32'h5555_5555, 1'b0, 12'd3, 1'b0},
    '{ROW_TYPED, '0,                            '0,     32'h0000_0001, 1'b0, 12'd4, 1'b0},
    '{ROW_TYPED, '0,                            '0,     32'h8000_0000, 1'b0, 12'd5, 1'b0},
    '{ROW_TYPED, '0,                            '0,     32'h7FFF_FFFF, 1'b0, 12'd6, 1'b0},
    '{ROW_TYPED, '0,                            '0,     32'h1234_5678, 1'b0, 12'd7, 1'b1},
    // No frame start after the last bin: the spectrum wraps to bin 0.
    '{ROW_TYPED, '0,                            '0,     32'hDEAD_BEEF, 1'b0, 12'd0, 1'b0},
    '{ROW_TYPED, '0,                            '0,     32'h0000_FFFF, 1'b0, 12'd1, 1'b0},
    // Frame start in the middle of a spectrum restarts at bin 0.
    '{ROW_TYPED, '0,                            '0,     32'hFFFF_0000, 1'b1, 12'd0, 1'b0},
    // Odd length is rounded down to 8; the widest window is clipped to its
    // half on both sides.
    '{ROW_CFG,   sswm_pkg::CFG_SPECTRUM_LENGTH, 13'd9,  32'h0000_0000, 1'b0, 12'd0, 1'b0},
    '{ROW_CFG,   sswm_pkg::CFG_HALF_WIDTH,      13'd31, 32'h0000_0000, 1'b0, 12'd0, 1'b0},
    '{ROW_FREE,  '0,                            '0,     32'hFFFF_FFFF, 1'b1, 12'd0, 1'b0},
    '{ROW_FREE,  '0,                            '0,     32'hFFFF_FFFF, 1'b0, 12'd0, 1'b0},
    '{ROW_FREE,  '0,                            '0,     32'h0000_0000, 1'b0, 12'd0, 1'b0},
    // Restart again: the three bins still pending above are dropped.
    '{ROW_FREE,  '0,                            '0,     32'hFFFF_FFFF, 1'b1, 12'd0, 1'b0},
    '{ROW_FREE,  '0,                            '0,     32'hFFFF_FFFF, 1'b0, 12'd0, 1'b0},
    '{ROW_FREE,  '0,                            '0,     32'hFFFF_FFFF, 1'b0, 12'd0, 1'b0},
    '{ROW_FREE,  '0,                            '0,     32'hFFFF_FFFF, 1'b0, 12'd0, 1'b0},
    '{ROW_FREE,  '0,                            '0,     32'hFFFF_FFFF, 1'b0, 12'd0, 1'b0},
    '{ROW_FREE,  '0,                            '0,     32'h0000_0003, 1'b0, 12'd0, 1'b0},
    '{ROW_FREE,  '0,                            '0,     32'h0000_0000, 1'b0, 12'd0, 1'b0},
    '{ROW_FREE,  '0,                            '0,     32'hFFFF_FFFF, 1'b0, 12'd0, 1'b0}
  };

  // Random phases: register setting, number of items, whether the phase
  // opens a fresh spectrum, whether stray frame starts are mixed in, and
  // whether both sides run without idling.
  typedef struct packed {
    logic [sswm_pkg::CFG_W-1:0] length;
    logic [sswm_pkg::HW_W-1:0]  width;
    int                         n_items;
    bit                         restart;
    bit                         noisy;
    bit                         steady;
  } phase_t;

  localparam int N_PHASES = 7;
  localparam phase_t PHASES [N_PHASES] = '{
    '{13'd16,   5'd3,  10, 1'b1, 1'b1, 1'b0},
    '{13'd10,   5'd1,  10, 1'b0, 1'b1, 1'b1},  // change lands mid-spectrum
    '{13'd64,   5'd31, 33, 1'b1, 1'b0, 1'b0},  // bin N/2 releases a full run
    '{13'd8191, 5'd5,  6,  1'b1, 1'b0, 1'b0},  // length above range clamps
    '{13'd5,    5'd2,  8,  1'b1, 1'b1, 1'b0},
    '{13'd25,   5'd9,  14, 1'b0, 1'b1, 1'b0},
    '{13'd22,   5'd0,  6,  1'b1, 1'b1, 1'b1}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [sswm_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [sswm_pkg::CFG_W-1:0]     cfg_data_i;

  sswm_in_if  samples_ch ();
  sswm_out_if means_ch ();

  split_spectrum_window_mean #(
    .MAX_POINTS     (MAX_POINTS),
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .RING_DEPTH     (RING_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_if       (samples_ch),
    .out_if      (means_ch)
  );

  // Shadow of the block: written registers, the values latched at bin 0,
  // the sample ring and the two bin counters.
  logic [sswm_pkg::VAL_W-1:0] ring_copy [RING_DEPTH];
  logic [sswm_pkg::CFG_W-1:0] length_reg;
  logic [sswm_pkg::HW_W-1:0]  width_reg;
  int unsigned                spec_n;
  int unsigned                spec_h;
  int unsigned                next_bin;
  int unsigned                next_mean;

  mean_t pending_means [$];
  int    means_predicted = 0;
  int    means_taken     = 0;
  int    mismatches      = 0;
  int    cycle_count     = 0;
  bit    steady          = 1'b0;
  bit    held_off        = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or a result never shows up.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned seen);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s expected %0h got %0h",
               cycle_count, what, want, seen);
    end
  endtask

  // Works out the smoothed bins that one accepted item releases and queues
  // them. N and H are latched on bin 0; a bin comes out once the last sample
  // of its clipped window is in, at most RUN_CAP per item.
  task automatic predict_window_means(input logic [sswm_pkg::VAL_W-1:0] power,
                                      input logic fs);
    int unsigned k;
    int unsigned half;
    int unsigned target;
    int unsigned run_end;
    int unsigned lo;
    int unsigned hi;
    int unsigned win_lo;
    int unsigned win_hi;
    longint unsigned sum;
    bit emits;
    mean_t m;
    if (fs || next_bin >= spec_n) next_bin = 0;
    if (next_bin == 0) begin
      spec_n = (length_reg < 8) ? 8 : ((length_reg > MAX_POINTS) ? MAX_POINTS : length_reg);
      spec_n = spec_n & ~32'd1;
      // A 5-bit width never exceeds the caps set by the ring and the run size.
      spec_h = width_reg;
      next_mean = 0;
    end
    k = next_bin;
    half = spec_n / 2;
    ring_copy[k % RING_DEPTH] = power;

    // The middle bin and the last bin flush whatever is left of their half.
    emits = 1'b1;
    target = k;
    if (k != half && k != spec_n - 1) begin
      if (k < half) emits = (k >= spec_h);
      else emits = (k >= spec_h + half + 1);
      target = k - spec_h;
    end

    if (emits && next_mean <= target) begin
      run_end = (target - next_mean >= RUN_CAP - 1) ? next_mean + RUN_CAP - 1 : target;
      while (next_mean <= run_end) begin
        lo = (next_mean <= half) ? 0 : half;
        hi = (next_mean <= half) ? half : spec_n - 1;
        win_lo = (next_mean >= lo + spec_h) ? next_mean - spec_h : lo;
        win_hi = (next_mean + spec_h <= hi) ? next_mean + spec_h : hi;
        sum = 0;
        for (int unsigned j = win_lo; j <= win_hi; j++) sum += ring_copy[j % RING_DEPTH];
        m.bin   = sswm_pkg::BIN_W'(next_mean);
        m.value = sswm_pkg::VAL_W'(sum / (win_hi - win_lo + 1));
        m.last  = (next_mean == run_end);
        m.done  = (next_mean == spec_n - 1);
        pending_means.push_back(m);
        means_predicted++;
        next_mean++;
      end
    end

    next_bin = (k + 1 >= spec_n) ? 0 : k + 1;
    if (next_bin == 0) next_mean = 0;
  endtask

  // Offers one item after a random gap and predicts its results once the
  // block has taken it. Returns at the rising edge of acceptance.
  task automatic offer_sample(input logic [sswm_pkg::VAL_W-1:0] power, input logic fs);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    samples_ch.valid       <= 1'b1;
    samples_ch.power_value <= power;
    samples_ch.frame_start <= fs;
    do @(posedge clk_i); while (samples_ch.ready !== 1'b1);
    predict_window_means(power, fs);
  endtask

  // Stops offering and waits until every expected result is out and the
  // block has had time to finish any silent work.
  task automatic drain_results();
    @(negedge clk_i);
    samples_ch.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [sswm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [sswm_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sswm_pkg::CFG_SPECTRUM_LENGTH) length_reg = data;
    else width_reg = sswm_pkg::HW_W'(data);
  endtask

  // Result side: random stalls, one long hold-off while the sender keeps
  // going, and an in-order check of every result against the queue.
  initial begin : result_sink
    mean_t got;
    mean_t want;
    int gap;
    means_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (!held_off && means_taken >= HOLD_AT) begin
        gap = HOLD_CYCLES;
        held_off = 1'b1;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        means_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      means_ch.ready <= 1'b1;
      do @(posedge clk_i); while (means_ch.valid !== 1'b1);
      got.bin   = means_ch.bin_index;
      got.value = means_ch.smoothed_value;
      got.last  = means_ch.last_of_run;
      got.done  = means_ch.frame_done;
      means_taken++;
      if (pending_means.size() == 0) begin
        report_mismatch("result with nothing expected, bin", 0, got.bin);
      end else begin
        want = pending_means.pop_front();
        if (got.bin !== want.bin) report_mismatch("bin_index", want.bin, got.bin);
        if (got.value !== want.value) begin
          report_mismatch("smoothed_value", want.value, got.value);
        end
        if (got.last !== want.last) report_mismatch("last_of_run", want.last, got.last);
        if (got.done !== want.done) report_mismatch("frame_done", want.done, got.done);
      end
      @(negedge clk_i);
    end
  end

  // Item side and overall sequence: reset, directed table, random phases.
  initial begin : stimulus
    logic [sswm_pkg::VAL_W-1:0] power;
    logic fs;
    int pred_mark;
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_index_i            = sswm_pkg::CFG_SPECTRUM_LENGTH;
    cfg_data_i             = '0;
    samples_ch.valid       = 1'b0;
    samples_ch.power_value = '0;
    samples_ch.frame_start = 1'b0;
    length_reg             = 13'd1024;
    width_reg              = 5'd4;
    spec_n                 = 1024;
    spec_h                 = 4;
    next_bin               = 0;
    next_mean              = 0;
    foreach (ring_copy[i]) ring_copy[i] = '0;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Typed rows replace the predicted result with the one
    // written in the table; the predictor still runs to keep its state.
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        drain_results();
        write_register(DIRECTED[r].reg_idx, DIRECTED[r].cfg_data);
      end else begin
        pred_mark = means_predicted;
        offer_sample(DIRECTED[r].power, DIRECTED[r].fs);
        if (DIRECTED[r].kind == ROW_TYPED) begin
          repeat (means_predicted - pred_mark) void'(pending_means.pop_back());
          pending_means.push_back(mean_t'{DIRECTED[r].bin, DIRECTED[r].power, 1'b1,
                                          DIRECTED[r].done});
        end
      end
    end

    // Random part. Mostly whole spectra that start with a frame start; at a
    // spectrum boundary the frame start is a coin toss so that wrapping is
    // covered, and noisy phases drop in stray restarts.
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_register(sswm_pkg::CFG_SPECTRUM_LENGTH, PHASES[p].length);
      write_register(sswm_pkg::CFG_HALF_WIDTH, sswm_pkg::CFG_W'(PHASES[p].width));
      steady = PHASES[p].steady;
      for (int i = 0; i < PHASES[p].n_items; i++) begin
        if (i == 0 && PHASES[p].restart) fs = 1'b1;
        else if (next_bin == 0 || next_bin >= spec_n) fs = $urandom_range(0, 1);
        else fs = PHASES[p].noisy && ($urandom_range(0, 24) == 0);
        case ($urandom_range(0, 7))
          0:       power = '0;
          1:       power = '1;
          2:       power = $urandom_range(0, 255);
          default: power = $urandom;
        endcase
        offer_sample(power, fs);
      end
    end

    steady = 1'b0;
    drain_results();
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
